// File: hw/rtl/apbfs_pkg.sv
// Shared types and constants for the all-pairs hop-distance unit.
// No dependencies; used by the interfaces, controller, datapath and top level.
package apbfs_pkg;

  localparam int CMD_W  = 2;
  localparam int VTX_W  = 6;
  localparam int DIST_W = 7;
  localparam int CNT_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_EDGE = 2'd0,
    CMD_CLEAR    = 2'd1,
    CMD_COMPUTE  = 2'd2,
    CMD_READ     = 2'd3
  } cmd_code_t;

  localparam logic [DIST_W-1:0] DIST_UNREACHED = 7'h7F;
  localparam logic [DIST_W-1:0] DIST_ZERO      = 7'h00;
  localparam logic [CNT_W-1:0]  VCOUNT_RESET   = 7'd64;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic add_wr;
    logic clr_edges;
    logic hclr;
    logic src_init;
    logic scan;
    logic level;
    logic finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_code_t cmd;
    logic      in_range;
    logic      sweep_last;
    logic      src_done;
    logic      scan_last;
    logic      reach_zero;
  } dp_sts_t;

endpackage

// File: hw/rtl/apbfs_if.sv
// Valid/ready channel interfaces for the all-pairs hop-distance unit.
// Depends on apbfs_pkg.
interface apbfs_in_if;
  logic                          valid;
  logic                          ready;
  logic [apbfs_pkg::CMD_W-1:0]   command;
  logic [apbfs_pkg::VTX_W-1:0]   from_vertex;
  logic [apbfs_pkg::VTX_W-1:0]   to_vertex;
  modport source (output valid, command, from_vertex, to_vertex, input ready);
  modport sink   (input valid, command, from_vertex, to_vertex, output ready);
endinterface

interface apbfs_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [apbfs_pkg::DIST_W-1:0] distance;
  logic                               status;
  modport source (output valid, distance, status, input ready);
  modport sink   (input valid, distance, status, output ready);
endinterface

interface apbfs_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [apbfs_pkg::CNT_W-1:0]  data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: hw/rtl/apbfs_ctrl.sv
// Sequencer for the all-pairs hop-distance unit: decodes words, runs the
// clear sweep and the per-source level loop. Depends on apbfs_pkg.
module apbfs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  apbfs_pkg::dp_sts_t  sts,
  output apbfs_pkg::dp_cmd_t  cmd
);
  import apbfs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECODE, ST_ADD, ST_HCLR, ST_SRC, ST_SCAN, ST_DRAIN, ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;

  // next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts.cmd)
          CMD_ADD_EDGE: state_nxt = sts.in_range ? ST_ADD : ST_DONE;
          CMD_CLEAR: begin
            cmd.clr_edges = 1'b1;
            state_nxt     = ST_DONE;
          end
          CMD_COMPUTE: state_nxt = ST_HCLR;
          default:     state_nxt = ST_DONE;
        endcase
      end
      ST_ADD: begin
        cmd.add_wr = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_HCLR: begin
        cmd.hclr = 1'b1;
        if (sts.sweep_last) state_nxt = ST_SRC;
      end
      ST_SRC: begin
        if (sts.src_done) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.src_init = 1'b1;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        cmd.level = 1'b1;
        state_nxt = sts.reach_zero ? ST_SRC : ST_SCAN;
      end
      ST_DONE: begin
        cmd.finish    = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // hold state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule

// File: hw/rtl/apbfs_dp.sv
// Datapath of the all-pairs hop-distance unit: adjacency and distance
// memories, frontier/visited sets, counters. Depends on apbfs_pkg.
module apbfs_dp #(
  parameter int NV = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [apbfs_pkg::CMD_W-1:0]      in_command,
  input  logic [apbfs_pkg::VTX_W-1:0]      in_from,
  input  logic [apbfs_pkg::VTX_W-1:0]      in_to,
  input  logic [apbfs_pkg::CNT_W-1:0]      vcount,
  input  apbfs_pkg::dp_cmd_t               cmd,
  output apbfs_pkg::dp_sts_t               sts,
  output logic signed [apbfs_pkg::DIST_W-1:0] out_distance,
  output logic                             out_status
);
  import apbfs_pkg::*;

  localparam int VW = $clog2(NV);
  localparam int HD = 2 ** (2 * VW);
  localparam logic [CNT_W-1:0] NV_C = CNT_W'(NV);

  // adjacency rows and per-row valid bits
  logic [NV-1:0]   adj_mem [NV];
  logic [NV-1:0]   adj_rd_r;
  logic [NV-1:0]   row_vld_r;
  // distance matrix
  logic [DIST_W-1:0] hop_mem [HD];
  logic [DIST_W-1:0] hop_rd_r;
  logic              computed_r;

  cmd_code_t         cmd_r;
  logic [VTX_W-1:0]  a_r, b_r;
  logic [CNT_W-1:0]  lim_r;
  logic [2*VW-1:0]   sweep_r;
  logic [VW:0]       src_r;
  logic [VW-1:0]     v_r;
  logic [DIST_W-1:0] lvl_r;
  logic [NV-1:0]     frontier_r, visited_r, acc_r, mask;
  logic              pend_r;
  logic [NV-1:0]     reach;
  logic [VW-1:0]     a_idx, b_idx, adj_raddr;
  logic              in_range;
  logic [NV-1:0]     merged;

  assign a_idx = a_r[VW-1:0];
  assign b_idx = b_r[VW-1:0];

  // live-vertex mask
  always_comb begin
    for (int i = 0; i < NV; i++) mask[i] = CNT_W'(i) < lim_r;
  end

  assign in_range  = (CNT_W'(a_r) < lim_r) && (CNT_W'(b_r) < lim_r);
  // include the row of the last scanned vertex, still in flight at the drain cycle
  assign reach     = (acc_r | (pend_r ? adj_rd_r : '0)) & mask & ~visited_r;
  assign adj_raddr = cmd.scan ? v_r : a_idx;
  assign merged    = row_vld_r[a_idx] ? adj_rd_r : '0;

  assign sts.cmd        = cmd_r;
  assign sts.in_range   = in_range;
  assign sts.sweep_last = &sweep_r;
  assign sts.src_done   = CNT_W'(src_r) == lim_r;
  assign sts.scan_last  = CNT_W'(v_r) + CNT_W'(1) == lim_r;
  assign sts.reach_zero = reach == '0;

  // adjacency memory: read one row, write one row per cycle
  always_ff @(posedge clk) begin
    adj_rd_r <= adj_mem[adj_raddr];
    if (cmd.add_wr) adj_mem[a_idx] <= merged | (NV'(1) << b_idx);
  end

  // distance memory: clear sweep or BFS level writes, registered read
  always_ff @(posedge clk) begin
    hop_rd_r <= hop_mem[{a_idx, b_idx}];
    if (cmd.hclr) begin
      hop_mem[sweep_r] <= DIST_UNREACHED;
    end else if (cmd.scan && frontier_r[v_r]) begin
      hop_mem[{src_r[VW-1:0], v_r}] <= lvl_r;
    end
  end

  // control-side state that reset clears
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r  <= '0;
      computed_r <= 1'b0;
      pend_r     <= 1'b0;
    end else begin
      if (cmd.clr_edges) row_vld_r <= '0;
      else if (cmd.add_wr) row_vld_r[a_idx] <= 1'b1;
      if (cmd.hclr) computed_r <= 1'b1;
      pend_r <= cmd.scan && frontier_r[v_r] && row_vld_r[v_r];
    end
  end

  // item latch, counters, sets and result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r   <= cmd_code_t'(in_command);
      a_r     <= in_from;
      b_r     <= in_to;
      lim_r   <= (vcount > NV_C) ? NV_C : vcount;
      sweep_r <= '0;
      src_r   <= '0;
    end
    if (cmd.hclr) sweep_r <= sweep_r + 1'b1;
    if (cmd.src_init) begin
      frontier_r <= NV'(1) << src_r[VW-1:0];
      visited_r  <= NV'(1) << src_r[VW-1:0];
      lvl_r      <= '0;
      v_r        <= '0;
      acc_r      <= '0;
    end
    if (cmd.scan) v_r <= v_r + 1'b1;
    // fold in the row that came back from the previous scan cycle
    if (pend_r && !cmd.src_init && !cmd.level) acc_r <= acc_r | adj_rd_r;
    if (cmd.level) begin
      if (reach == '0) begin
        src_r <= src_r + 1'b1;
      end else begin
        frontier_r <= reach;
        visited_r  <= visited_r | reach;
        lvl_r      <= lvl_r + 1'b1;
        v_r        <= '0;
        acc_r      <= '0;
      end
    end
    if (cmd.finish) begin
      if ((cmd_r inside {CMD_ADD_EDGE, CMD_READ}) && !in_range) begin
        out_status   <= 1'b1;
        out_distance <= DIST_ZERO;
      end else if (cmd_r == CMD_READ) begin
        out_status   <= 1'b0;
        out_distance <= computed_r ? hop_rd_r : DIST_UNREACHED;
      end else begin
        out_status   <= 1'b0;
        out_distance <= DIST_ZERO;
      end
    end
  end
endmodule

// File: hw/rtl/all_pairs_bfs_hop_distance_unit.sv
// Top level of the all-pairs BFS hop-distance unit: channel glue, vertex
// count register, controller and datapath. Depends on apbfs_pkg, apbfs_if.
//
//   channel  dir  fields
//   in_chan  in   command[1:0], from_vertex[5:0], to_vertex[5:0]
//   out_chan out  distance[6:0] signed, status
//   cfg_chan in   data[6:0] = vertex_count
//
// One word at a time. Add passes through decode, the row write (if both
// vertices are in range) and finish; clear and read go from decode to finish.
// Compute decodes, then clears all 2^(2*clog2(NV)) distance entries in a sweep
// (one distance-memory write port), then per source a setup step and, per BFS
// level, adjacency-row reads (one row per cycle, n vertices in use) and a drain.
// Reset is synchronous; no edges, vertex_count 64, all distances read -1.
// A result waits in its output register; the next word is taken once it leaves.
module all_pairs_bfs_hop_distance_unit #(
  parameter int MAX_VERTICES = 64
) (
  input logic               clk,
  input logic               rst_n,
  apbfs_in_if.sink          in_chan,
  apbfs_out_if.source       out_chan,
  apbfs_cfg_if.sink         cfg_chan
);
  import apbfs_pkg::*;

  localparam int NV = (MAX_VERTICES > 64) ? 64 : MAX_VERTICES;

  logic [CNT_W-1:0] vcount_r;
  dp_cmd_t          cmd;
  dp_sts_t          sts;

  // hold vertex count
  assign cfg_chan.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= VCOUNT_RESET;
    end else if (cfg_chan.valid) begin
      vcount_r <= cfg_chan.data;
    end
  end

  apbfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  apbfs_dp #(.NV(NV)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_command   (in_chan.command),
    .in_from      (in_chan.from_vertex),
    .in_to        (in_chan.to_vertex),
    .vcount       (vcount_r),
    .cmd          (cmd),
    .sts          (sts),
    .out_distance (out_chan.distance),
    .out_status   (out_chan.status)
  );
endmodule
